// ===== rtl/core/aurm_pkg.sv =====
package aurm_pkg;

    // Field widths
    localparam int ANGLE_IN_W = 12;
    localparam int TICK_W     = 32;
    localparam int RPM_W      = 24;
    localparam int UA_W       = 48;
    localparam int TURN_W     = 32;
    localparam int QUAD_W     = 3;
    localparam int INTERVAL_W = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_START_ANGLE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = 2'd1;
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd200;

    // 960000 = 1875 * 2^9 (ms per minute times 16, per full turn)
    localparam int RPM_MUL_W = 11;
    localparam logic [RPM_MUL_W-1:0] RPM_MUL = 11'd1875;
    localparam int RPM_SHIFT = 9;

    // Divider: one overflow step plus 24 quotient bits
    localparam int QUO_W     = RPM_W + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = 5;

    localparam logic [RPM_W-1:0] RPM_MAX_CODE = 24'h7FFFFF;
    localparam logic [RPM_W-1:0] RPM_MIN_CODE = 24'h800000;

    // Request into the speed unit
    typedef struct packed {
        logic              start;
        logic [UA_W-1:0]   dang;
        logic [TICK_W-1:0] dt;
    } aurm_spd_req_t;

    // Response from the speed unit
    typedef struct packed {
        logic             done;
        logic [RPM_W-1:0] rpm;
    } aurm_spd_rsp_t;

endpackage

// ===== rtl/core/aurm_speed_unit.sv =====
// Speed from angle and time deltas: |dang| * 1875, then a restoring divide by
// dt over one overflow step and 24 quotient steps, then sign and saturation.
module aurm_speed_unit #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  aurm_pkg::aurm_spd_req_t req,
    output aurm_pkg::aurm_spd_rsp_t rsp
);

    localparam int SH_N  = (ANGLE_BITS < aurm_pkg::RPM_SHIFT) ?
                           (aurm_pkg::RPM_SHIFT - ANGLE_BITS) : 0;
    localparam int SH_D  = (ANGLE_BITS > aurm_pkg::RPM_SHIFT) ?
                           (ANGLE_BITS - aurm_pkg::RPM_SHIFT) : 0;
    localparam int MUL_W = aurm_pkg::UA_W + aurm_pkg::RPM_MUL_W;
    localparam int NUM_W = MUL_W + SH_N;
    localparam int DEN_W = aurm_pkg::TICK_W + SH_D + aurm_pkg::QUO_W - 1;
    localparam int W     = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ABS  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SAT  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [aurm_pkg::UA_W-1:0]   dang_reg;
    logic [aurm_pkg::TICK_W-1:0] dt_reg;
    logic                        neg_reg;
    logic [aurm_pkg::UA_W-1:0]   mag_reg;
    logic [W-1:0]                rem_reg, rem_next;
    logic [W-1:0]                ds_reg, ds_next;
    logic [aurm_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic [aurm_pkg::STEP_W-1:0] step_reg, step_next;

    logic [MUL_W-1:0]          prod;
    logic                      ge;
    logic [aurm_pkg::RPM_W-1:0] q_lo, q_neg, rpm;
    logic                      pos_ovf, neg_ovf;

    // Product and shared compare/subtract
    assign prod = MUL_W'(mag_reg) * MUL_W'(aurm_pkg::RPM_MUL);
    assign ge   = (rem_reg >= ds_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    state_next = S_ABS;
                end
            end
            S_ABS: state_next = S_MUL;
            S_MUL: state_next = S_DIV;
            S_DIV: begin
                if (step_reg == aurm_pkg::STEP_W'(aurm_pkg::DIV_STEPS - 1)) begin
                    state_next = S_SAT;
                end
            end
            S_SAT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Divider step
    always_comb begin
        rem_next  = ge ? (rem_reg - ds_reg) : rem_reg;
        ds_next   = ds_reg >> 1;
        quo_next  = {quo_reg[aurm_pkg::QUO_W-2:0], ge};
        step_next = step_reg + aurm_pkg::STEP_W'(1);
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                dang_reg <= req.dang;
                dt_reg   <= req.dt;
            end
            S_ABS: begin
                neg_reg <= dang_reg[aurm_pkg::UA_W-1];
                mag_reg <= dang_reg[aurm_pkg::UA_W-1] ? (~dang_reg + aurm_pkg::UA_W'(1))
                                                      : dang_reg;
            end
            S_MUL: begin
                rem_reg  <= W'(prod) << SH_N;
                ds_reg   <= W'(dt_reg) << (SH_D + aurm_pkg::QUO_W - 1);
                quo_reg  <= '0;
                step_reg <= '0;
            end
            S_DIV: begin
                rem_reg  <= rem_next;
                ds_reg   <= ds_next;
                quo_reg  <= quo_next;
                step_reg <= step_next;
            end
            default: begin
            end
        endcase
    end

    // Sign and saturation
    always_comb begin
        q_lo    = quo_reg[aurm_pkg::RPM_W-1:0];
        q_neg   = (~q_lo) + aurm_pkg::RPM_W'(1);
        pos_ovf = quo_reg[aurm_pkg::QUO_W-1] | quo_reg[aurm_pkg::RPM_W-1];
        neg_ovf = quo_reg[aurm_pkg::QUO_W-1] |
                  (quo_reg[aurm_pkg::RPM_W-1] & (|quo_reg[aurm_pkg::RPM_W-2:0]));
        if (neg_reg) begin
            rpm = neg_ovf ? aurm_pkg::RPM_MIN_CODE : q_neg;
        end else begin
            rpm = pos_ovf ? aurm_pkg::RPM_MAX_CODE : q_lo;
        end
    end

    assign rsp.done = (state_reg == S_SAT);
    assign rsp.rpm  = rpm;

endmodule

// ===== rtl/core/angle_unwrap_rpm_meter_top.sv =====
// Shaft speed meter for an absolute angle sensor. Each beat carries a raw angle
// and a millisecond timestamp; the block removes the start angle, counts turns
// on quadrant 4 to 1 and 1 to 4 moves, and when at least min_interval_ms have
// passed since the last window it returns speed in 1/16 rpm, saturated to 24
// bits, with updated set. Every input beat gives exactly one result beat. A
// beat that closes no window passes from the unwrap state to the emit state;
// one that closes a window first waits for the 25-step restoring divider in
// the speed unit. One beat is in work at a time; a finished result waits in
// the output register while the next beat is accepted.
module angle_unwrap_rpm_meter_top #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [aurm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [aurm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [aurm_pkg::ANGLE_IN_W-1:0]      s_angle,
    input  logic [aurm_pkg::TICK_W-1:0]          s_tick_ms,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [aurm_pkg::RPM_W-1:0]    m_rpm_q4,
    output logic                                 m_updated
);

    localparam int UA_W   = aurm_pkg::UA_W;
    localparam int TURN_W = aurm_pkg::TURN_W;
    localparam int AIN_W  = aurm_pkg::ANGLE_IN_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UNWRAP = 3'd1;
    localparam logic [2:0] ST_DELTA  = 3'd2;
    localparam logic [2:0] ST_SPEED  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    localparam logic [aurm_pkg::QUAD_W-1:0] QUAD_NONE  = 3'd0;
    localparam logic [aurm_pkg::QUAD_W-1:0] QUAD_FIRST = 3'd1;
    localparam logic [aurm_pkg::QUAD_W-1:0] QUAD_LAST  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [AIN_W-1:0]               start_angle_reg;
    logic [aurm_pkg::INTERVAL_W-1:0] min_interval_reg;
    logic [aurm_pkg::QUAD_W-1:0]    last_quad_reg;
    logic [TURN_W-1:0]              turn_reg;
    logic [UA_W-1:0]                window_angle_reg;
    logic [aurm_pkg::TICK_W-1:0]    window_tick_reg;
    logic [aurm_pkg::RPM_W-1:0]     speed_reg;
    logic                           m_valid_reg;

    logic [AIN_W-1:0]            angle_reg;
    logic [aurm_pkg::TICK_W-1:0] tick_reg;
    logic [UA_W-1:0]             ua_reg;
    logic [aurm_pkg::TICK_W-1:0] dt_reg;
    logic                        upd_reg;
    logic [aurm_pkg::RPM_W-1:0]  m_rpm_reg;
    logic                        m_upd_reg;

    logic [ANGLE_BITS+AIN_W-1:0]     raw_ext, sa_ext;
    logic [ANGLE_BITS-1:0]           corr;
    logic [aurm_pkg::QUAD_W-1:0]     quad;
    logic [TURN_W-1:0]               turn_next;
    logic [UA_W-1:0]                 turn_ext, ua;
    logic [aurm_pkg::TICK_W-1:0]     dt;
    logic [aurm_pkg::INTERVAL_W-1:0] lim;
    logic                            upd;
    logic                            out_free;

    aurm_pkg::aurm_spd_req_t spd_req;
    aurm_pkg::aurm_spd_rsp_t spd_rsp;

    // Angle correction, quadrant and turn tracking
    always_comb begin
        raw_ext   = {{ANGLE_BITS{1'b0}}, angle_reg};
        sa_ext    = {{ANGLE_BITS{1'b0}}, start_angle_reg};
        corr      = raw_ext[ANGLE_BITS-1:0] - sa_ext[ANGLE_BITS-1:0];
        quad      = {1'b0, corr[ANGLE_BITS-1:ANGLE_BITS-2]} + aurm_pkg::QUAD_W'(1);
        turn_next = turn_reg;
        if (last_quad_reg != QUAD_NONE) begin
            if (quad == QUAD_FIRST && last_quad_reg == QUAD_LAST) begin
                turn_next = turn_reg + TURN_W'(1);
            end else if (quad == QUAD_LAST && last_quad_reg == QUAD_FIRST) begin
                turn_next = turn_reg - TURN_W'(1);
            end
        end
        turn_ext = {{(UA_W-TURN_W){turn_next[TURN_W-1]}}, turn_next};
        ua       = {turn_ext[UA_W-1-ANGLE_BITS:0], corr};
    end

    // Window check
    always_comb begin
        dt  = tick_reg - window_tick_reg;
        lim = (min_interval_reg == '0) ? aurm_pkg::INTERVAL_W'(1) : min_interval_reg;
        upd = (dt >= aurm_pkg::TICK_W'(lim));
    end

    assign out_free = !m_valid_reg || m_ready;

    // Speed unit request
    assign spd_req.start = (state_reg == ST_DELTA);
    assign spd_req.dang  = ua_reg - window_angle_reg;
    assign spd_req.dt    = dt_reg;

    aurm_speed_unit #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_speed (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (spd_req),
        .rsp    (spd_rsp)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UNWRAP;
                end
            end
            ST_UNWRAP: state_next = upd ? ST_DELTA : ST_EMIT;
            ST_DELTA:  state_next = ST_SPEED;
            ST_SPEED: begin
                if (spd_rsp.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            start_angle_reg  <= '0;
            min_interval_reg <= aurm_pkg::MIN_INTERVAL_RST;
            last_quad_reg    <= QUAD_NONE;
            turn_reg         <= '0;
            window_angle_reg <= '0;
            window_tick_reg  <= '0;
            speed_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    aurm_pkg::REG_START_ANGLE:  start_angle_reg  <= cfg_wdata[AIN_W-1:0];
                    aurm_pkg::REG_MIN_INTERVAL: min_interval_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_UNWRAP) begin
                last_quad_reg <= quad;
                turn_reg      <= turn_next;
            end
            if (state_reg == ST_DELTA) begin
                window_angle_reg <= ua_reg;
                window_tick_reg  <= tick_reg;
            end
            if (state_reg == ST_SPEED && spd_rsp.done) begin
                speed_reg <= spd_rsp.rpm;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            angle_reg <= s_angle;
            tick_reg  <= s_tick_ms;
        end
        if (state_reg == ST_UNWRAP) begin
            ua_reg  <= ua;
            dt_reg  <= dt;
            upd_reg <= upd;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_rpm_reg <= speed_reg;
            m_upd_reg <= upd_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_rpm_q4  = m_rpm_reg;
    assign m_updated = m_upd_reg;

    // Checks
    a_done_in_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        spd_rsp.done |-> state_reg == ST_SPEED)
        else $error("speed unit finished outside its wait state");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a beat is in work");

    a_speed_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(speed_reg) |-> ($past(state_reg) == ST_SPEED && upd_reg))
        else $error("speed changed without a closed window");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS  = 12;
    localparam int DIV_SHIFT   = ANGLE_BITS - 9;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int SETTLE_CYC  = 40;
    localparam int HOLD_CYC    = 300;
    localparam int PHASE_BEATS = 250;
    localparam int MAX_REPORTS = 50;

    // register indexes the block does not decode
    localparam logic [aurm_pkg::CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [aurm_pkg::CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    // quadrant codes, zero means none seen yet
    localparam logic [2:0] QUAD_NONE  = 3'd0;
    localparam logic [2:0] QUAD_FIRST = 3'd1;
    localparam logic [2:0] QUAD_LAST  = 3'd4;

    localparam bit [63:0] SPEED_SCALE = 64'd1875;
    localparam bit [63:0] POS_LIMIT   = 64'd8388607;
    localparam bit [63:0] NEG_LIMIT   = 64'd8388608;

    typedef struct {
        logic signed [aurm_pkg::RPM_W-1:0] rpm;
        logic                              updated;
    } reading_t;

    // Speed predictor plus the queue of readings still owed by the block
    class rpm_scoreboard;
        bit [11:0]                   start_code;
        bit [15:0]                   interval;
        bit [2:0]                    last_quad;
        bit [aurm_pkg::TURN_W-1:0]   turns;
        bit [aurm_pkg::UA_W-1:0]     win_angle;
        bit [aurm_pkg::TICK_W-1:0]   win_tick;
        bit [aurm_pkg::RPM_W-1:0]    speed;
        reading_t                    expected_readings[$];
        int                          errors;

        function new();
            start_code = '0;
            interval   = aurm_pkg::MIN_INTERVAL_RST;
            last_quad  = QUAD_NONE;
            turns      = '0;
            win_angle  = '0;
            win_tick   = '0;
            speed      = '0;
            errors     = 0;
        endfunction

        function void apply_reg(logic [aurm_pkg::CFG_ADDR_W-1:0] idx,
                                logic [aurm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                aurm_pkg::REG_START_ANGLE:  start_code = data[11:0];
                aurm_pkg::REG_MIN_INTERVAL: interval   = data;
                default: ;
            endcase
        endfunction

        // 960000 * dAngle / (dT * 4096), truncated, saturated to 24 bits
        function bit [aurm_pkg::RPM_W-1:0] speed_from_delta(bit [aurm_pkg::UA_W-1:0] dang,
                                                            bit [aurm_pkg::TICK_W-1:0] dt);
            bit [63:0] mag;
            bit [63:0] quo;
            mag = dang[aurm_pkg::UA_W-1] ? (64'h1_0000_0000_0000 - {16'd0, dang})
                                         : {16'd0, dang};
            quo = (mag * SPEED_SCALE) / ({32'd0, dt} << DIV_SHIFT);
            if (dang[aurm_pkg::UA_W-1]) begin
                if (quo > NEG_LIMIT)
                    quo = NEG_LIMIT;
                return 24'd0 - quo[aurm_pkg::RPM_W-1:0];
            end
            if (quo > POS_LIMIT)
                quo = POS_LIMIT;
            return quo[aurm_pkg::RPM_W-1:0];
        endfunction

        function void note_sample(logic [aurm_pkg::ANGLE_IN_W-1:0] raw,
                                  logic [aurm_pkg::TICK_W-1:0] tick);
            bit [11:0]                 corr;
            bit [2:0]                  quad;
            bit [aurm_pkg::UA_W-1:0]   unwrapped;
            bit [aurm_pkg::TICK_W-1:0] dt;
            bit [aurm_pkg::TICK_W-1:0] lim;
            reading_t                  r;
            corr = raw - start_code;
            quad = {1'b0, corr[11:10]} + 3'd1;
            // turn counting on 4->1 and 1->4 moves
            if (last_quad != QUAD_NONE && quad != last_quad) begin
                if (quad == QUAD_FIRST && last_quad == QUAD_LAST)
                    turns = turns + 1;
                else if (quad == QUAD_LAST && last_quad == QUAD_FIRST)
                    turns = turns - 1;
            end
            last_quad = quad;
            unwrapped = {{4{turns[aurm_pkg::TURN_W-1]}}, turns, corr};
            dt  = tick - win_tick;
            lim = (interval == 0) ? 32'd1 : {16'd0, interval};
            r.updated = 1'b0;
            if (dt >= lim) begin
                speed     = speed_from_delta(unwrapped - win_angle, dt);
                win_angle = unwrapped;
                win_tick  = tick;
                r.updated = 1'b1;
            end
            r.rpm = speed;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(logic signed [aurm_pkg::RPM_W-1:0] rpm, logic updated);
            reading_t want;
            if (expected_readings.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result beat, rpm_q4 %0d updated %b",
                             $time, rpm, updated);
                return;
            end
            want = expected_readings.pop_front();
            if (rpm !== want.rpm) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: rpm_q4 mismatch, expected %0d, actual %0d",
                             $time, want.rpm, rpm);
            end
            if (updated !== want.updated) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: updated mismatch, expected %b, actual %b",
                             $time, want.updated, updated);
            end
        endfunction

        function int outstanding();
            return expected_readings.size();
        endfunction
    endclass

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  cfg_wr_en;
    logic [aurm_pkg::CFG_ADDR_W-1:0]       cfg_addr;
    logic [aurm_pkg::CFG_DATA_W-1:0]       cfg_wdata;
    logic                                  s_valid;
    logic                                  s_ready;
    logic [aurm_pkg::ANGLE_IN_W-1:0]       s_angle;
    logic [aurm_pkg::TICK_W-1:0]           s_tick_ms;
    logic                                  m_valid;
    logic                                  m_ready;
    logic signed [aurm_pkg::RPM_W-1:0]     m_rpm_q4;
    logic                                  m_updated;

    rpm_scoreboard sb;
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_request;
    int            interval_now;
    int unsigned   beats_sent;
    int unsigned   cycle_count;
    logic [11:0]   cur_angle;
    logic [31:0]   cur_tick;

    angle_unwrap_rpm_meter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_angle   (s_angle),
        .s_tick_ms (s_tick_ms),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rpm_q4  (m_rpm_q4),
        .m_updated (m_updated)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    // result side: ready with random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge aclk);
                hold_request = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result monitor
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_reading(m_rpm_q4, m_updated);
        end
    end

    // one sample beat, with random gaps in front of it
    task automatic send_beat(logic [11:0] angle_code, logic [31:0] tick);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_angle   <= angle_code;
        s_tick_ms <= tick;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_sample(angle_code, tick);
        beats_sent++;
    endtask

    task automatic write_reg(logic [aurm_pkg::CFG_ADDR_W-1:0] idx,
                             logic [aurm_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.apply_reg(idx, data);
        if (idx == aurm_pkg::REG_MIN_INTERVAL)
            interval_now = data;
    endtask

    // drop valid and let the block drain before touching registers
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // random sample streams until the phase's beat count is reached
    task automatic run_random(int unsigned count);
        int unsigned stop_at;
        int          kind;
        int          steps;
        int          vel;
        int          lim_now;
        int          dmax;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            kind    = $urandom_range(0, 99);
            lim_now = (interval_now == 0) ? 1 : interval_now;
            if (kind < 60) begin
                // steady rotation with random speed and sample spacing
                vel   = $urandom_range(0, 2000) - 1000;
                steps = $urandom_range(8, 40);
                dmax  = $urandom_range(1, lim_now + lim_now / 2 + 1);
                repeat (steps) begin
                    cur_angle = cur_angle + 12'(vel + $urandom_range(0, 16) - 8);
                    cur_tick  = cur_tick + $urandom_range(0, dmax);
                    send_beat(cur_angle, cur_tick);
                end
            end else if (kind < 72) begin
                // many turns inside one millisecond, then close the window
                vel = $urandom_range(0, 1) ? 1000 : -1000;
                repeat (45) begin
                    cur_angle = cur_angle + 12'(vel + $urandom_range(0, 40) - 20);
                    send_beat(cur_angle, cur_tick);
                end
                cur_tick = cur_tick + lim_now;
                send_beat(cur_angle, cur_tick);
            end else if (kind < 87) begin
                // noise: arbitrary angle and timestamp
                steps = $urandom_range(1, 5);
                repeat (steps) begin
                    cur_angle = 12'($urandom);
                    cur_tick  = $urandom;
                    send_beat(cur_angle, cur_tick);
                end
            end else if (kind < 92) begin
                // timestamp about to wrap
                cur_tick = 32'hFFFF_FFFF - $urandom_range(0, 500);
                vel      = $urandom_range(0, 600) - 300;
                steps    = $urandom_range(5, 20);
                repeat (steps) begin
                    cur_angle = cur_angle + 12'(vel);
                    cur_tick  = cur_tick + $urandom_range(0, lim_now);
                    send_beat(cur_angle, cur_tick);
                end
            end else begin
                // dither across the zero crossing, turn count flips up and down
                steps = $urandom_range(4, 16);
                repeat (steps) begin
                    cur_angle = sb.start_code + ($urandom_range(0, 1) ?
                                12'(4095 - $urandom_range(0, 30)) : 12'($urandom_range(0, 30)));
                    cur_tick  = cur_tick + $urandom_range(0, lim_now);
                    send_beat(cur_angle, cur_tick);
                end
            end
        end
    endtask

    // main sequence
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_angle      = '0;
        s_tick_ms    = '0;
        hold_request = 1'b0;
        beats_sent   = 0;
        interval_now = aurm_pkg::MIN_INTERVAL_RST;
        sb            = new();
        send_idle_pct = 35;
        recv_idle_pct = 75;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, first sample, turns both ways, window edges
        send_beat(12'd0,    32'd0);
        send_beat(12'd4095, 32'd50);
        send_beat(12'd0,    32'd100);
        send_beat(12'd1023, 32'd150);
        send_beat(12'd2048, 32'd199);
        send_beat(12'd3072, 32'd200);
        send_beat(12'd4095, 32'd300);
        send_beat(12'd0,    32'd400);
        send_beat(12'd3000, 32'd401);
        send_beat(12'd2001, 32'd600);
        send_beat(12'd2001, 32'hFFFF_FF80);
        send_beat(12'd1000, 32'h0000_0050);
        send_beat(12'd1000, 32'd10);
        send_beat(12'd4095, 32'hFFFF_FFFF);
        send_beat(12'd0,    32'h0000_00C7);

        // directed: zero interval, top start angle, spare registers ignored
        settle();
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        write_reg(aurm_pkg::REG_MIN_INTERVAL, 16'h0000);
        write_reg(aurm_pkg::REG_START_ANGLE, 16'h0FFF);
        send_beat(12'd4095, 32'd1000);
        send_beat(12'd4094, 32'd1000);
        send_beat(12'd4094, 32'd1000);
        send_beat(12'd0,    32'd1001);
        send_beat(12'd2047, 32'd1002);
        cur_angle = 12'd2047;
        cur_tick  = 32'd1002;

        // random phases over register settings and idle patterns
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(aurm_pkg::REG_START_ANGLE, 16'h0000);
                    write_reg(aurm_pkg::REG_MIN_INTERVAL, 16'd1);
                end
                1: begin
                    write_reg(aurm_pkg::REG_START_ANGLE, 16'hFFFF);
                    write_reg(aurm_pkg::REG_MIN_INTERVAL, 16'hFFFF);
                end
                2: begin
                    write_reg(aurm_pkg::REG_START_ANGLE, 16'($urandom));
                    write_reg(aurm_pkg::REG_MIN_INTERVAL, 16'd0);
                end
                3: begin
                    write_reg(aurm_pkg::REG_START_ANGLE, 16'($urandom));
                    write_reg(aurm_pkg::REG_MIN_INTERVAL, 16'($urandom_range(2, 50)));
                end
                4: begin
                    write_reg(aurm_pkg::REG_START_ANGLE, 16'($urandom));
                    write_reg(aurm_pkg::REG_MIN_INTERVAL, aurm_pkg::MIN_INTERVAL_RST);
                end
                5: begin
                    write_reg(aurm_pkg::REG_START_ANGLE, 16'($urandom));
                    write_reg(aurm_pkg::REG_MIN_INTERVAL, 16'd1);
                end
                6: begin
                    write_reg(aurm_pkg::REG_START_ANGLE, 16'($urandom));
                    write_reg(aurm_pkg::REG_MIN_INTERVAL, 16'($urandom_range(1, 1000)));
                end
                default: begin
                    write_reg(REG_SPARE_2, 16'($urandom));
                    write_reg(REG_SPARE_3, 16'($urandom));
                    write_reg(aurm_pkg::REG_START_ANGLE, 16'($urandom));
                    write_reg(aurm_pkg::REG_MIN_INTERVAL, 16'($urandom_range(1, 20)));
                end
            endcase
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));

            if (phase < 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 75;
            end else if (phase < 6) begin
                send_idle_pct = 75;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver hold-off so the input side backs up
            if (phase == 1)
                hold_request = 1'b1;
            run_random(PHASE_BEATS);
        end

        settle();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
